/* rtl/core/apld_pkg.sv */
// ----------------------------------------------------------------------------
// apld_pkg
// Shared types and constants for the ATA PIO LBA28 disk device.
// ----------------------------------------------------------------------------
package apld_pkg;

    // Sector geometry
    localparam int SECTOR_WORDS = 256;
    localparam int WORD_AW      = $clog2(SECTOR_WORDS);
    localparam int LBA_W        = 28;
    localparam int LEFT_W       = 9;
    localparam logic [WORD_AW-1:0] WORD_LAST = WORD_AW'(SECTOR_WORDS - 1);
    localparam logic [LEFT_W-1:0]  MAX_SECTORS = LEFT_W'(256);

    // Bus access kind
    localparam logic ACC_WRITE = 1'b0;
    localparam logic ACC_READ  = 1'b1;

    // Command codes
    localparam logic [7:0] CMD_READ_SECTORS  = 8'h20;
    localparam logic [7:0] CMD_WRITE_SECTORS = 8'h30;

    // Register read values
    localparam logic [7:0] ERR_ABORT   = 8'h04;
    localparam logic [7:0] DEV_FIXED   = 8'hE0;
    localparam logic [7:0] STAT_READY  = 8'h40;
    localparam logic [7:0] STAT_DRQ    = 8'h08;
    localparam logic [7:0] STAT_ERR    = 8'h01;

    // Task-file port offsets
    typedef enum logic [2:0] {
        PORT_DATA   = 3'd0,
        PORT_FEAT   = 3'd1,
        PORT_COUNT  = 3'd2,
        PORT_LBA0   = 3'd3,
        PORT_LBA1   = 3'd4,
        PORT_LBA2   = 3'd5,
        PORT_DEVICE = 3'd6,
        PORT_CMD    = 3'd7
    } t_port;

    // Transfer mode
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } t_mode;

    // Controller to datapath command
    typedef struct packed {
        logic accept;
    } t_dp_cmd;

endpackage

/* rtl/core/ata_pio_lba28_disk_device_unit.sv */
// ----------------------------------------------------------------------------
// ata_pio_lba28_disk_device_unit
// ATA PIO task-file device with LBA28 addressing and an internal sector
// store; one bus access in, one read word out.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_command, i_port_offset,
//          |           |                         | i_write_data
//  out     | from block| o_out_valid/i_out_stall | o_read_data
//
//  One access per cycle, every kind, while not stalled: a data port read is
//  served by the store's registered read port, which feeds the output
//  directly, so a result is presented the cycle after its access is taken.
//  Reset clears the task file and ends any transfer; the store contents are
//  undefined until written and no clearing pass runs.
//  A held result stalls the input only while the output is stalled.
//
module ata_pio_lba28_disk_device_unit #(
    parameter int STORE_SECTORS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [2:0]  i_port_offset,
    input  logic [15:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_read_data
);

    apld_pkg::t_dp_cmd dp_cmd;

    // Handshake controller
    apld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd)
    );

    // Task file, sequencing and store
    apld_datapath #(
        .STORE_SECTORS (STORE_SECTORS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_command     (i_command),
        .i_port_offset (i_port_offset),
        .i_write_data  (i_write_data),
        .o_read_data   (o_read_data)
    );

endmodule

/* rtl/core/apld_ctrl.sv */
// ----------------------------------------------------------------------------
// apld_ctrl
// Handshake controller: tracks the output holding register and decides
// when a bus access transfer is taken.
// ----------------------------------------------------------------------------
module apld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output apld_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        S_EMPTY,
        S_FULL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Stall only while a result is held and not being taken
    assign o_in_stall  = (r_state == S_FULL) && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_FULL);
    assign o_cmd.accept = accept;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_EMPTY: begin
                if (accept) n_state = S_FULL;
            end
            S_FULL: begin
                if (!i_out_stall && !accept) n_state = S_EMPTY;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/apld_datapath.sv */
// ----------------------------------------------------------------------------
// apld_datapath
// Task-file registers, transfer sequencing and the sector store, with the
// registered read data path.
// ----------------------------------------------------------------------------
module apld_datapath #(
    parameter int STORE_SECTORS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  apld_pkg::t_dp_cmd i_cmd,
    input  logic              i_command,
    input  logic [2:0]        i_port_offset,
    input  logic [15:0]       i_write_data,
    output logic [15:0]       o_read_data
);

    localparam int SECT_AW   = (STORE_SECTORS > 1) ? $clog2(STORE_SECTORS) : 1;
    localparam int MEM_DEPTH = STORE_SECTORS * apld_pkg::SECTOR_WORDS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int LBA_W     = apld_pkg::LBA_W;
    localparam int LEFT_W    = apld_pkg::LEFT_W;
    localparam int WORD_AW   = apld_pkg::WORD_AW;

    // Task-file and transfer state
    logic [LBA_W-1:0]    r_lba,   n_lba;
    logic [7:0]          r_count, n_count;
    logic [LEFT_W-1:0]   r_left,  n_left;
    logic [WORD_AW-1:0]  r_wpos,  n_wpos;
    apld_pkg::t_mode     r_mode,  n_mode;
    logic                r_err,   n_err;

    // Output path
    logic [15:0]         r_out_data;
    logic                r_out_mem;
    logic [15:0]         r_mem_q;

    // Sector store
    logic [15:0]         mem [MEM_DEPTH];

    logic                is_read;
    apld_pkg::t_port     port;
    logic [7:0]          wbyte;
    logic                lba_in_range;
    logic [SECT_AW+WORD_AW-1:0] addr_full;
    logic [MEM_AW-1:0]   mem_addr;
    logic                data_rd;
    logic                data_wr;
    logic [LEFT_W-1:0]   sector_n;
    logic [LBA_W:0]      lba_end;
    logic                out_of_range;
    logic [LEFT_W-1:0]   left_dec;
    logic [15:0]         reg_rdata;
    logic [7:0]          status;

    assign is_read = (i_command == apld_pkg::ACC_READ);
    assign port    = apld_pkg::t_port'(i_port_offset);
    assign wbyte   = i_write_data[7:0];

    // Store address; an LBA past the store maps to word zero
    assign lba_in_range = (r_lba < LBA_W'(STORE_SECTORS));
    assign addr_full    = {r_lba[SECT_AW-1:0], r_wpos};
    assign mem_addr     = lba_in_range ? addr_full[MEM_AW-1:0] : '0;

    // Data port transfers inside a matching transfer
    assign data_rd = i_cmd.accept && is_read && (port == apld_pkg::PORT_DATA)
                     && (r_mode == apld_pkg::MODE_READ);
    assign data_wr = i_cmd.accept && !is_read && (port == apld_pkg::PORT_DATA)
                     && (r_mode == apld_pkg::MODE_WRITE);

    // Command range check; count of zero means the full 256
    assign sector_n     = (r_count == 8'd0) ? apld_pkg::MAX_SECTORS : LEFT_W'(r_count);
    assign lba_end      = {1'b0, r_lba} + (LBA_W + 1)'(sector_n);
    assign out_of_range = (lba_end > (LBA_W + 1)'(STORE_SECTORS));
    assign left_dec     = (r_left != '0) ? r_left - LEFT_W'(1) : r_left;

    // Status byte
    always_comb begin
        status = apld_pkg::STAT_READY;
        if (r_mode != apld_pkg::MODE_IDLE) status = status | apld_pkg::STAT_DRQ;
        if (r_err) status = status | apld_pkg::STAT_ERR;
    end

    // Register read mux (data port word comes from the store)
    always_comb begin
        reg_rdata = 16'd0;
        unique case (port)
            apld_pkg::PORT_DATA:   reg_rdata = 16'd0;
            apld_pkg::PORT_FEAT:   reg_rdata = r_err ? {8'd0, apld_pkg::ERR_ABORT} : 16'd0;
            apld_pkg::PORT_COUNT:  reg_rdata = {8'd0, r_count};
            apld_pkg::PORT_LBA0:   reg_rdata = {8'd0, r_lba[7:0]};
            apld_pkg::PORT_LBA1:   reg_rdata = {8'd0, r_lba[15:8]};
            apld_pkg::PORT_LBA2:   reg_rdata = {8'd0, r_lba[23:16]};
            apld_pkg::PORT_DEVICE: reg_rdata = {8'd0, apld_pkg::DEV_FIXED | {4'd0, r_lba[27:24]}};
            apld_pkg::PORT_CMD:    reg_rdata = {8'd0, status};
        endcase
    end

    // Task-file update and transfer sequencing
    always_comb begin
        n_lba   = r_lba;
        n_count = r_count;
        n_left  = r_left;
        n_wpos  = r_wpos;
        n_mode  = r_mode;
        n_err   = r_err;
        if (data_rd || data_wr) begin
            n_wpos = r_wpos + WORD_AW'(1);
            if (r_wpos == apld_pkg::WORD_LAST) begin
                n_lba  = r_lba + LBA_W'(1);
                n_left = left_dec;
                if (left_dec == '0) n_mode = apld_pkg::MODE_IDLE;
            end
        end else if (i_cmd.accept && !is_read) begin
            unique case (port)
                apld_pkg::PORT_DATA:   ;
                apld_pkg::PORT_FEAT:   ;
                apld_pkg::PORT_COUNT:  n_count = wbyte;
                apld_pkg::PORT_LBA0:   n_lba[7:0]   = wbyte;
                apld_pkg::PORT_LBA1:   n_lba[15:8]  = wbyte;
                apld_pkg::PORT_LBA2:   n_lba[23:16] = wbyte;
                apld_pkg::PORT_DEVICE: n_lba[27:24] = wbyte[3:0];
                apld_pkg::PORT_CMD: begin
                    n_mode = apld_pkg::MODE_IDLE;
                    n_wpos = '0;
                    n_left = '0;
                    if (wbyte != apld_pkg::CMD_READ_SECTORS &&
                        wbyte != apld_pkg::CMD_WRITE_SECTORS) begin
                        n_err = 1'b1;
                    end else if (out_of_range) begin
                        n_err = 1'b1;
                    end else begin
                        n_err  = 1'b0;
                        n_left = sector_n;
                        n_mode = (wbyte == apld_pkg::CMD_READ_SECTORS) ?
                                 apld_pkg::MODE_READ : apld_pkg::MODE_WRITE;
                    end
                end
            endcase
        end
    end

    // State and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lba     <= '0;
            r_count   <= '0;
            r_left    <= '0;
            r_wpos    <= '0;
            r_mode    <= apld_pkg::MODE_IDLE;
            r_err     <= 1'b0;
            r_out_mem <= 1'b0;
        end else begin
            r_lba   <= n_lba;
            r_count <= n_count;
            r_left  <= n_left;
            r_wpos  <= n_wpos;
            r_mode  <= n_mode;
            r_err   <= n_err;
            if (i_cmd.accept) r_out_mem <= data_rd;
        end
    end

    // Register result, zero for writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_out_data <= is_read ? reg_rdata : 16'd0;
        end
    end

    // Sector store: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (data_wr) mem[mem_addr] <= i_write_data;
        if (data_rd) r_mem_q <= mem[mem_addr];
    end

    assign o_read_data = r_out_mem ? r_mem_q : r_out_data;

endmodule
